### hw/rtl/dsf_pkg.sv
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter package
// Shared widths, the blank code and the digit-to-segment table.
// ----------------------------------------------------------------------------
package dsf_pkg;

	localparam int VALUE_W   = 32;
	localparam int SEG_W     = 8;
	localparam int DIGIT_W   = 4;
	localparam int POSITIONS = 8;

	typedef logic [VALUE_W-1:0]                 value_t;
	typedef logic [SEG_W-1:0]                   seg_t;
	typedef logic [DIGIT_W-1:0]                 digit_t;
	typedef logic [POSITIONS-1:0][DIGIT_W-1:0]  digits_t;

	localparam seg_t BLANK_CODE = 8'hff;

	// Reciprocal of ten for a 32-bit dividend: q = (v * RECIP_TEN) >> RECIP_SHIFT.
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hcccc_cccd;
	localparam int                 RECIP_SHIFT = 35;

	// Active-low common-anode segment codes for the decimal digits.
	function automatic seg_t seg_code(input digit_t d);
		seg_t code;
		unique case (d)
			4'd0:    code = 8'hc0;
			4'd1:    code = 8'hf9;
			4'd2:    code = 8'ha4;
			4'd3:    code = 8'hb0;
			4'd4:    code = 8'h99;
			4'd5:    code = 8'h92;
			4'd6:    code = 8'h82;
			4'd7:    code = 8'hf8;
			4'd8:    code = 8'h80;
			4'd9:    code = 8'h90;
			default: code = BLANK_CODE;
		endcase
		return code;
	endfunction

endpackage

### hw/rtl/dsf_value_if.sv
// ----------------------------------------------------------------------------
// Value channel
// Valid/ready channel that carries one unsigned binary value.
// ----------------------------------------------------------------------------
interface dsf_value_if import dsf_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

### hw/rtl/dsf_seg_if.sv
// ----------------------------------------------------------------------------
// Segment channel
// Valid/ready channel that carries eight seven-segment codes, leftmost first.
// ----------------------------------------------------------------------------
interface dsf_seg_if import dsf_pkg::*; ();
	logic valid;
	logic ready;
	seg_t seg_pos0;
	seg_t seg_pos1;
	seg_t seg_pos2;
	seg_t seg_pos3;
	seg_t seg_pos4;
	seg_t seg_pos5;
	seg_t seg_pos6;
	seg_t seg_pos7;

	modport source (output valid, input ready,
		output seg_pos0, output seg_pos1, output seg_pos2, output seg_pos3,
		output seg_pos4, output seg_pos5, output seg_pos6, output seg_pos7);
	modport sink (input valid, output ready,
		input seg_pos0, input seg_pos1, input seg_pos2, input seg_pos3,
		input seg_pos4, input seg_pos5, input seg_pos6, input seg_pos7);
endinterface

### hw/rtl/dsf_digit.sv
// ----------------------------------------------------------------------------
// Digit extraction stage
// One pipeline stage: divides the value by ten with a reciprocal multiply and
// stores the remainder as the digit of one display position.
// ----------------------------------------------------------------------------
module dsf_digit import dsf_pkg::*; #(
	parameter int POS = 7
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  value_t  in_value,
	input  digits_t in_digits,
	output logic    out_valid,
	output value_t  out_value,
	output digits_t out_digits
);

	logic [2*VALUE_W-1:0] prod;
	value_t               quot;
	value_t               rem_full;
	digits_t              digits_next;

	logic    valid_q;
	value_t  value_q;
	digits_t digits_q;

	always_comb begin
		prod     = {{VALUE_W{1'b0}}, in_value} * {{VALUE_W{1'b0}}, RECIP_TEN};
		quot     = VALUE_W'(prod >> RECIP_SHIFT);
		rem_full = in_value - (quot << 3) - (quot << 1);
		digits_next      = in_digits;
		digits_next[POS] = rem_full[DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q  <= quot;
			digits_q <= digits_next;
		end
	end

	assign out_valid  = valid_q;
	assign out_value  = value_q;
	assign out_digits = digits_q;

endmodule

### hw/rtl/decimal_seven_segment_formatter_top.sv
// NUM_DIGITS above 8 behaves as 8. Throughput: one value per cycle while the
// output is not stalled by dout.ready.
// The depth is set by the divide-by-ten chain, one digit stage per shown digit.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter
// Converts an unsigned 32-bit value into eight active-low seven-segment codes,
// lowest NUM_DIGITS decimal digits only, with leading zeros blanked.
// ----------------------------------------------------------------------------
module decimal_seven_segment_formatter_top import dsf_pkg::*; #(
	parameter int NUM_DIGITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	dsf_value_if.sink    din,
	dsf_seg_if.source    dout
);

	// Only eight positions exist, so a wider digit count is clipped to eight,
	// and at least one digit is always shown.
	localparam int WIN = (NUM_DIGITS > POSITIONS) ? POSITIONS :
		((NUM_DIGITS < 1) ? 1 : NUM_DIGITS);

	// Pipeline layout:
	//   index 0        input capture register
	//   index 1..WIN   one digit stage each, rightmost digit first
	//   output stage   segment mapping and leading-zero blanking
	logic    valid_s  [0:WIN];
	value_t  value_s  [0:WIN];
	digits_t digits_s [0:WIN];

	// adv[i] is high when stage i may load a new transfer this cycle: the stage
	// is empty, or its content moves on in the same cycle. This lets bubbles
	// collapse and a stall hold every stage without loss or repetition.
	logic adv [0:WIN+1];

	logic out_valid_q;
	seg_t seg_q    [POSITIONS];
	seg_t seg_next [POSITIONS];

	always_comb begin
		adv[WIN+1] = !out_valid_q || dout.ready;
		for (int i = WIN; i >= 0; i--) begin
			adv[i] = !valid_s[i] || adv[i+1];
		end
	end

	assign din.ready = adv[0];

	// Input capture. Digits start at zero, so positions left of the shown
	// window read as leading zeros and are blanked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv[0]) begin
			valid_s[0] <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			value_s[0]  <= din.value;
			digits_s[0] <= '0;
		end
	end

	// Digit stages: stage k extracts the k-th digit from the right.
	for (genvar k = 0; k < WIN; k++) begin : g_digit
		dsf_digit #(
			.POS (POSITIONS - 1 - k)
		) u_digit (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv[k+1]),
			.in_valid   (valid_s[k]),
			.in_value   (value_s[k]),
			.in_digits  (digits_s[k]),
			.out_valid  (valid_s[k+1]),
			.out_value  (value_s[k+1]),
			.out_digits (digits_s[k+1])
		);
	end

	// Leading-zero blanking scans from the leftmost position; the first nonzero
	// digit ends the blank run, and every digit after it is shown, zeros too.
	// A value of zero therefore blanks all positions.
	always_comb begin
		logic leading;
		leading = 1'b1;
		for (int p = 0; p < POSITIONS; p++) begin
			if (leading && (digits_s[WIN][p] == '0)) begin
				seg_next[p] = BLANK_CODE;
			end else begin
				leading     = 1'b0;
				seg_next[p] = seg_code(digits_s[WIN][p]);
			end
		end
	end

	// Output register: holds the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv[WIN+1]) begin
			out_valid_q <= valid_s[WIN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[WIN+1]) begin
			seg_q <= seg_next;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.seg_pos0 = seg_q[0];
	assign dout.seg_pos1 = seg_q[1];
	assign dout.seg_pos2 = seg_q[2];
	assign dout.seg_pos3 = seg_q[3];
	assign dout.seg_pos4 = seg_q[4];
	assign dout.seg_pos5 = seg_q[5];
	assign dout.seg_pos6 = seg_q[6];
	assign dout.seg_pos7 = seg_q[7];

endmodule
